// File: rtl/bnps_pkg.sv
// Package for the Bezier nearest-parameter search block.
// Holds default sizes, opcode, register index and status codes.
// Used by bnps_dist_pipe and bezier_nearest_parameter_search.
package bnps_pkg;

  // Default sizes.
  localparam int C_MAX_POINTS   = 64;
  localparam int C_SAMPLE_STEPS = 1000;
  localparam int C_COORD_WIDTH  = 16;

  // Input item kinds, carried on s_tuser.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic REG_POINT_COUNT = 1'b0;
  localparam logic REG_CLOSED      = 1'b1;

  // Result status codes, carried on m_tuser.
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

endpackage

// File: rtl/bnps_dist_pipe.sv
// Sample pipeline: walks steps 1..SAMPLE_STEPS-1, evaluates the cubic curve
// and its squared distance to the query point, and keeps the first minimum.
// Depends on bnps_pkg for default sizes.
module bnps_dist_pipe
  import bnps_pkg::*;
#(
  parameter int SAMPLE_STEPS = C_SAMPLE_STEPS,
  parameter int COORD_WIDTH  = C_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [COORD_WIDTH-1:0]        a_anchor_x,
  input  logic [COORD_WIDTH-1:0]        a_anchor_y,
  input  logic [COORD_WIDTH-1:0]        a_out_x,
  input  logic [COORD_WIDTH-1:0]        a_out_y,
  input  logic [COORD_WIDTH-1:0]        b_in_x,
  input  logic [COORD_WIDTH-1:0]        b_in_y,
  input  logic [COORD_WIDTH-1:0]        b_anchor_x,
  input  logic [COORD_WIDTH-1:0]        b_anchor_y,
  input  logic [COORD_WIDTH-1:0]        q_x,
  input  logic [COORD_WIDTH-1:0]        q_y,
  output logic                          done,
  output logic [$clog2(SAMPLE_STEPS+1)-1:0] best_step
);

  localparam int NB  = $clog2(SAMPLE_STEPS + 1);
  localparam int WB  = 3 * NB + 2;
  localparam int PW  = COORD_WIDTH + WB + 1;
  localparam int DW  = PW - 1;
  localparam int HW  = (DW + 1) / 2;
  localparam int LW  = DW - HW;
  localparam int SQW = 2 * DW;
  localparam int NST = 9;
  localparam logic [NB-1:0] N_STEPS = NB'(SAMPLE_STEPS);
  localparam logic [NB-1:0] LAST_S  = NB'(SAMPLE_STEPS - 1);
  localparam logic [WB-1:0] N_CUBE  =
    WB'(64'(SAMPLE_STEPS) * 64'(SAMPLE_STEPS) * 64'(SAMPLE_STEPS));

  // Step generator.
  logic          running;
  logic [NB-1:0] s_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      s_cnt   <= '0;
    end else if (start) begin
      running <= 1'b1;
      s_cnt   <= NB'(1);
    end else if (running) begin
      if (s_cnt == LAST_S) begin
        running <= 1'b0;
      end
      s_cnt <= s_cnt + NB'(1);
    end
  end

  // Valid, last and step tags travel alongside the data.
  logic [NST:1] vld;
  logic [NST:1] lst;
  logic [NB-1:0] tag [1:NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      lst <= '0;
    end else begin
      vld <= {vld[NST-1:1], running};
      lst <= {lst[NST-1:1], running && (s_cnt == LAST_S)};
    end
  end

  always_ff @(posedge clk) begin
    tag[1] <= s_cnt;
    for (int i = 2; i <= NST; i++) begin
      tag[i] <= tag[i-1];
    end
  end

  // Stage 1: squares of s and r = N - s.
  logic [NB-1:0]   s1, r1;
  logic [2*NB-1:0] ss1, rr1;

  always_ff @(posedge clk) begin
    s1  <= s_cnt;
    r1  <= N_STEPS - s_cnt;
    ss1 <= s_cnt * s_cnt;
    rr1 <= (N_STEPS - s_cnt) * (N_STEPS - s_cnt);
  end

  // Stage 2: Bernstein weights scaled by N cubed.
  logic [WB-1:0] w0, w1, w2, w3;

  always_ff @(posedge clk) begin
    w0 <= rr1 * r1;
    w1 <= (rr1 * s1) * WB'(3);
    w2 <= (ss1 * r1) * WB'(3);
    w3 <= ss1 * s1;
  end

  // Stage 3: weighted control coordinates; query point scaled by N cubed.
  logic signed [PW-1:0] tx0, tx1, tx2, tx3, ty0, ty1, ty2, ty3;
  logic signed [PW-1:0] qnx, qny;

  always_ff @(posedge clk) begin
    tx0 <= $signed(a_anchor_x) * $signed({1'b0, w0});
    tx1 <= $signed(a_out_x)    * $signed({1'b0, w1});
    tx2 <= $signed(b_in_x)     * $signed({1'b0, w2});
    tx3 <= $signed(b_anchor_x) * $signed({1'b0, w3});
    ty0 <= $signed(a_anchor_y) * $signed({1'b0, w0});
    ty1 <= $signed(a_out_y)    * $signed({1'b0, w1});
    ty2 <= $signed(b_in_y)     * $signed({1'b0, w2});
    ty3 <= $signed(b_anchor_y) * $signed({1'b0, w3});
    qnx <= $signed(q_x) * $signed({1'b0, N_CUBE});
    qny <= $signed(q_y) * $signed({1'b0, N_CUBE});
  end

  // Stage 4: partial sums.
  logic signed [PW-1:0] sxa, sxb, sya, syb;

  always_ff @(posedge clk) begin
    sxa <= tx0 + tx1;
    sxb <= tx2 + tx3;
    sya <= ty0 + ty1;
    syb <= ty2 + ty3;
  end

  // Stage 5: offset from the query point.
  logic signed [PW-1:0] dfx, dfy;

  always_ff @(posedge clk) begin
    dfx <= sxa + sxb - qnx;
    dfy <= sya + syb - qny;
  end

  // Stage 6: magnitudes.
  logic [DW-1:0] mgx, mgy;

  always_ff @(posedge clk) begin
    mgx <= dfx[PW-1] ? DW'(-dfx) : DW'(dfx);
    mgy <= dfy[PW-1] ? DW'(-dfy) : DW'(dfy);
  end

  // Stage 7: squares split into half-width partial products.
  logic [2*LW-1:0]  hhx, hhy;
  logic [DW-1:0]    hlx, hly;
  logic [2*HW-1:0]  llx, lly;

  always_ff @(posedge clk) begin
    hhx <= mgx[DW-1:HW] * mgx[DW-1:HW];
    hlx <= mgx[DW-1:HW] * mgx[HW-1:0];
    llx <= mgx[HW-1:0]  * mgx[HW-1:0];
    hhy <= mgy[DW-1:HW] * mgy[DW-1:HW];
    hly <= mgy[DW-1:HW] * mgy[HW-1:0];
    lly <= mgy[HW-1:0]  * mgy[HW-1:0];
  end

  // Stage 8: assemble the full squares.
  logic [SQW-1:0] sqx, sqy;

  always_ff @(posedge clk) begin
    sqx <= SQW'({hhx, {(2*HW){1'b0}}}) + SQW'({hlx, {(HW+1){1'b0}}}) + SQW'(llx);
    sqy <= SQW'({hhy, {(2*HW){1'b0}}}) + SQW'({hly, {(HW+1){1'b0}}}) + SQW'(lly);
  end

  // Stage 9: squared distance.
  logic [SQW:0] sq_dist;

  always_ff @(posedge clk) begin
    sq_dist <= {1'b0, sqx} + {1'b0, sqy};
  end

  // Running minimum; the first sample always wins, later ones only if smaller.
  logic          found;
  logic [SQW:0]  best_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      found         <= 1'b0;
      best_distance <= '0;
      best_step     <= '0;
      done          <= 1'b0;
    end else begin
      done <= vld[NST] && lst[NST];
      if (start) begin
        found <= 1'b0;
      end else if (vld[NST] && (!found || sq_dist < best_distance)) begin
        found         <= 1'b1;
        best_distance <= sq_dist;
        best_step     <= tag[NST];
      end
    end
  end

endmodule

// File: rtl/bezier_nearest_parameter_search.sv
// Top level of the Bezier nearest-parameter search block: control point
// table memory, item sequencing, configuration and the result register.
// Depends on bnps_pkg and bnps_dist_pipe.
//
// Channel  Direction  Contents
// s_*      in         tuser = opcode; tdata = index, entry coords, query point
// m_*      out        tuser = status; tdata = best_step
// cfg_*    in         cfg_index 0 = point_count, 1 = closed
//
// A write or a rejected query is answered from idle. A valid query reads
// two table entries (states S_RDA, S_RDB, S_LDB), streams SAMPLE_STEPS-1
// samples through the distance pipeline at one per cycle and drains it.
// Reset is synchronous; table contents are undefined until written.
// A new item is taken only in idle with the result register free or leaving.
module bezier_nearest_parameter_search
  import bnps_pkg::*;
#(
  parameter int MAX_POINTS   = C_MAX_POINTS,
  parameter int SAMPLE_STEPS = C_SAMPLE_STEPS,
  parameter int COORD_WIDTH  = C_COORD_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [5:0] index, [21:6] anchor_x, [37:22] anchor_y, [53:38] handle_in_x,
  // [69:54] handle_in_y, [85:70] handle_out_x, [101:86] handle_out_y,
  // [117:102] query_x, [133:118] query_y, [135:134] zero
  input  logic [135:0] s_tdata,
  // [0] opcode
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [NB-1:0] best_step, zero above
  output logic [(($clog2(SAMPLE_STEPS+1)+7)/8)*8-1:0] m_tdata,
  // [0] status
  output logic         m_tuser,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [6:0]   cfg_data
);

  localparam int NB  = $clog2(SAMPLE_STEPS + 1);
  localparam int ODW = ((NB + 7) / 8) * 8;
  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = COORD_WIDTH;
  localparam int EW  = 6 * CW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDA  = 3'd1;
  localparam logic [2:0] S_RDB  = 3'd2;
  localparam logic [2:0] S_LDB  = 3'd3;
  localparam logic [2:0] S_RUN  = 3'd4;

  // Input fields.
  logic [5:0] in_index;
  assign in_index = s_tdata[5:0];

  // Configuration registers.
  logic [6:0] point_count;
  logic       closed;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      closed      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POINT_COUNT: point_count <= cfg_data;
        REG_CLOSED:      closed      <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  // Control point table: entry holds anchor, in handle, out handle (x, y each).
  logic [EW-1:0] mem [MAX_POINTS];
  logic [EW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] addr_a, addr_b;
  logic          mem_we;
  logic [EW-1:0] wr_data;

  assign wr_data = {CW'(s_tdata[101:86]), CW'(s_tdata[85:70]),
                    CW'(s_tdata[69:54]),  CW'(s_tdata[53:38]),
                    CW'(s_tdata[37:22]),  CW'(s_tdata[21:6])};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(in_index)] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequencer.
  logic [2:0]    state;
  logic          accept;
  logic          idx_ok;
  logic          has_next;
  logic          has_curve;
  logic          res_load;
  logic [EW-1:0] ent_a, ent_b;
  logic [CW-1:0] qx, qy;
  logic          pipe_start;
  logic          pipe_done;
  logic [NB-1:0] pipe_best;

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign idx_ok   = (32'(in_index) < MAX_POINTS) && ({1'b0, in_index} < point_count);
  assign has_next = (32'(in_index) + 1 < MAX_POINTS)
                    && ({1'b0, in_index} + 7'd1 < point_count);
  assign mem_we   = accept && (s_tuser == OP_WRITE) && (32'(in_index) < MAX_POINTS);
  assign rd_addr  = (state == S_RDA) ? addr_a : addr_b;
  assign pipe_start = (state == S_LDB);

  // A result is loaded for a write or rejected query, or when a search ends.
  assign res_load = ((state == S_IDLE) && accept && !(s_tuser == OP_QUERY && idx_ok))
                    || ((state == S_RUN) && pipe_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && s_tuser == OP_QUERY && idx_ok) begin
            state <= S_RDA;
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: state <= S_LDB;
        S_LDB: state <= S_RUN;
        S_RUN: begin
          if (pipe_done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Query capture, entry loads; an open path with no next entry reads zeros.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      addr_a    <= AW'(in_index);
      addr_b    <= has_next ? AW'(32'(in_index) + 1) : '0;
      has_curve <= has_next || closed;
      qx        <= CW'(s_tdata[117:102]);
      qy        <= CW'(s_tdata[133:118]);
    end
    if (state == S_RDB) begin
      ent_a <= has_curve ? rd_data : '0;
    end
    if (state == S_LDB) begin
      ent_b <= has_curve ? rd_data : '0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      m_tuser <= (s_tuser == OP_QUERY && !idx_ok) ? ST_RANGE : ST_OK;
      m_tdata <= '0;
    end else if (state == S_RUN && pipe_done) begin
      m_tuser <= ST_OK;
      m_tdata <= ODW'(pipe_best);
    end
  end

  // Incoming handle of the segment end entry.
  logic [CW-1:0] rd_data_b_in_x, rd_data_b_in_y;
  assign rd_data_b_in_x = ent_b[3*CW-1:2*CW];
  assign rd_data_b_in_y = ent_b[4*CW-1:3*CW];

  bnps_dist_pipe #(
    .SAMPLE_STEPS (SAMPLE_STEPS),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_pipe (
    .clk        (clk),
    .rst        (rst),
    .start      (pipe_start),
    .a_anchor_x (ent_a[CW-1:0]),
    .a_anchor_y (ent_a[2*CW-1:CW]),
    .a_out_x    (ent_a[5*CW-1:4*CW]),
    .a_out_y    (ent_a[6*CW-1:5*CW]),
    .b_in_x     (rd_data_b_in_x),
    .b_in_y     (rd_data_b_in_y),
    .b_anchor_x (ent_b[CW-1:0]),
    .b_anchor_y (ent_b[2*CW-1:CW]),
    .q_x        (qx),
    .q_y        (qy),
    .done       (pipe_done),
    .best_step  (pipe_best)
  );

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for bezier_nearest_parameter_search.
// Streams table writes and nearest-parameter queries and checks every result
// against a built-in predictor. Depends on bnps_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
  import bnps_pkg::*;

  typedef struct {
    logic               op;
    logic [5:0]         idx;
    logic signed [15:0] ax, ay, hix, hiy, hox, hoy, qx, qy;
  } path_item_t;

  typedef struct {
    logic       status;
    logic [9:0] step;
  } search_result_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [135:0] s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [15:0]  m_tdata;
  logic         m_tuser;
  logic         cfg_we;
  logic         cfg_index;
  logic [6:0]   cfg_data;

  bezier_nearest_parameter_search DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: control point table and configuration.
  logic signed [15:0] anc_x [64], anc_y [64];
  logic signed [15:0] hin_x [64], hin_y [64];
  logic signed [15:0] hout_x [64], hout_y [64];
  int unsigned        point_count_q;
  bit                 closed_q;

  path_item_t     pending_q [$];
  search_result_t expected_q [$];
  path_item_t     cur_item;

  int errors;
  int n_writes, n_queries, n_range, n_results;
  int burst_left, gap_left;
  int stall_left;
  bit pressure_done;
  int idle_cycles;

  // Apply a write, flag a bad index, or sample the segment for the first closest step.
  function automatic search_result_t search_nearest(path_item_t it);
    search_result_t res;
    int unsigned cnt, b;
    bit          has_curve;
    longint      r, s, w0, w1, w2, w3, px, py, dx, dy;
    logic [127:0] sq_dist, best_dist;
    res.status = ST_OK;
    res.step   = '0;
    if (it.op == OP_WRITE) begin
      anc_x[it.idx] = it.ax;  anc_y[it.idx] = it.ay;
      hin_x[it.idx] = it.hix; hin_y[it.idx] = it.hiy;
      hout_x[it.idx] = it.hox; hout_y[it.idx] = it.hoy;
      return res;
    end
    cnt = (point_count_q > 64) ? 64 : point_count_q;
    if (it.idx >= cnt) begin
      res.status = ST_RANGE;
      return res;
    end
    has_curve = 1'b1;
    b = 0;
    if (it.idx + 1 < cnt) b = it.idx + 1;
    else if (!closed_q) has_curve = 1'b0;
    best_dist = '0;
    for (int st = 1; st < 1000; st++) begin
      s = st;
      r = 1000 - s;
      w0 = r * r * r;
      w1 = 3 * r * r * s;
      w2 = 3 * r * s * s;
      w3 = s * s * s;
      if (has_curve) begin
        px = longint'(anc_x[it.idx]) * w0 + longint'(hout_x[it.idx]) * w1
           + longint'(hin_x[b]) * w2 + longint'(anc_x[b]) * w3;
        py = longint'(anc_y[it.idx]) * w0 + longint'(hout_y[it.idx]) * w1
           + longint'(hin_y[b]) * w2 + longint'(anc_y[b]) * w3;
      end else begin
        px = 0;
        py = 0;
      end
      dx = px - longint'(it.qx) * 64'sd1000000000;
      dy = py - longint'(it.qy) * 64'sd1000000000;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sq_dist = {64'd0, dx} * {64'd0, dx} + {64'd0, dy} * {64'd0, dy};
      if (st == 1 || sq_dist < best_dist) begin
        best_dist = sq_dist;
        res.step  = st[9:0];
      end
    end
    return res;
  endfunction

  // Coordinates: half full range, half small values near the origin.
  function automatic logic signed [15:0] rand_coord();
    if ($urandom_range(0, 1)) return 16'($urandom);
    return 16'(int'($urandom_range(0, 400)) - 200);
  endfunction

  function automatic path_item_t make_write(int idx);
    path_item_t it;
    it.op = OP_WRITE;
    it.idx = 6'(idx);
    it.ax = rand_coord(); it.ay = rand_coord();
    it.hix = rand_coord(); it.hiy = rand_coord();
    it.hox = rand_coord(); it.hoy = rand_coord();
    it.qx = 16'($urandom); it.qy = 16'($urandom);
    return it;
  endfunction

  function automatic path_item_t make_query(int idx, logic signed [15:0] qx,
                                            logic signed [15:0] qy);
    path_item_t it;
    it = make_write(idx);
    it.op = OP_QUERY;
    it.qx = qx;
    it.qy = qy;
    return it;
  endfunction

  // Random mix: mostly in-range queries, some writes and out-of-range indexes.
  task automatic queue_random(int n);
    int cnt, pick;
    logic signed [15:0] qx, qy;
    cnt = (point_count_q > 64) ? 64 : point_count_q;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        pending_q.push_back(make_write($urandom_range(0, 63)));
      end else begin
        if (pick < 45 || cnt == 0) pick = $urandom_range(0, 63);
        else pick = $urandom_range(0, cnt - 1);
        if ($urandom_range(0, 2) == 0) begin
          qx = 16'(int'(anc_x[pick]) + int'($urandom_range(0, 60)) - 30);
          qy = 16'(int'(anc_y[pick]) + int'($urandom_range(0, 60)) - 30);
        end else begin
          qx = rand_coord();
          qy = rand_coord();
        end
        pending_q.push_back(make_query(pick, qx, qy));
      end
    end
  endtask

  // Checked away from the active edge so that the driver's updates have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == REG_POINT_COUNT) point_count_q = value;
    else closed_q = value[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sender: bursts of items with random gaps; predicts each accepted transaction.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (s_tvalid && s_tready) begin
        expected_q.push_back(search_nearest(cur_item));
        if (cur_item.op == OP_WRITE) n_writes++;
        else n_queries++;
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        cur_item = pending_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= cur_item.op;
        s_tdata <= {2'b00, cur_item.qy, cur_item.qx, cur_item.hoy, cur_item.hox,
                    cur_item.hiy, cur_item.hix, cur_item.ay, cur_item.ax, cur_item.idx};
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, stretches of full readiness, and one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
      pressure_done <= 1'b0;
    end else if (!pressure_done && n_results == 150) begin
      pressure_done <= 1'b1;
      stall_left <= 400;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if ((n_results / 40) % 2 == 1) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    search_result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected result transaction: status=%0d step=%0d", m_tuser, m_tdata);
      end else begin
        exp_res = expected_q.pop_front();
        if (exp_res.status == ST_RANGE) n_range++;
        if (m_tuser !== exp_res.status || m_tdata !== {6'd0, exp_res.step}) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch: expected status=%0d step=%0d, got status=%0d step=%0d",
                     exp_res.status, exp_res.step, m_tuser, m_tdata);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either stream.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 10000) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus sequence.
  initial begin
    errors = 0;
    n_writes = 0; n_queries = 0; n_range = 0; n_results = 0;
    point_count_q = 0;
    closed_q = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Query with nothing in use must be rejected; then load the whole table.
    pending_q.push_back(make_query(0, 16'sd0, 16'sd0));
    for (int i = 0; i < 64; i++) pending_q.push_back(make_write(i));
    wait_idle();

    // Directed checks on an open path of the full size.
    write_reg(REG_POINT_COUNT, 7'd64);
    write_reg(REG_CLOSED, 7'd0);
    begin
      path_item_t it;
      it = make_write(0);
      it.ax = 16'sh7fff; it.ay = 16'sh8000; it.hix = 16'sh8000; it.hiy = 16'sh7fff;
      it.hox = 16'sh7fff; it.hoy = 16'sh7fff;
      pending_q.push_back(it);
      it = make_write(1);
      it.ax = 16'sh8000; it.ay = 16'sh7fff; it.hix = 16'sh7fff; it.hiy = 16'sh8000;
      it.hox = 16'sh8000; it.hoy = 16'sh8000;
      pending_q.push_back(it);
    end
    pending_q.push_back(make_query(0, 16'sh7fff, 16'sh8000));  // at the start anchor
    pending_q.push_back(make_query(0, 16'sh8000, 16'sh7fff));  // at the end anchor
    pending_q.push_back(make_query(0, 16'sh8000, 16'sh8000));
    pending_q.push_back(make_query(0, 16'sh7fff, 16'sh7fff));
    pending_q.push_back(make_query(63, 16'sd1234, -16'sd77));  // open path, last index
    pending_q.push_back(make_query(62, 16'sd0, 16'sd0));
    wait_idle();

    // Closed path: the last segment wraps to entry 0.
    write_reg(REG_CLOSED, 7'd1);
    pending_q.push_back(make_query(63, 16'sd0, 16'sd0));
    pending_q.push_back(make_query(63, 16'sh7fff, 16'sh8000));
    queue_random(50);
    wait_idle();

    // A count above the table size behaves as the full table.
    write_reg(REG_POINT_COUNT, 7'd127);
    queue_random(50);
    wait_idle();

    // Single point: index 0 is the last one, indexes above are out of range.
    write_reg(REG_POINT_COUNT, 7'd1);
    pending_q.push_back(make_query(0, 16'sd5, 16'sd5));
    pending_q.push_back(make_query(1, 16'sd5, 16'sd5));
    queue_random(40);
    wait_idle();
    write_reg(REG_CLOSED, 7'd0);
    queue_random(40);
    wait_idle();

    // No points in use: every query is rejected, writes still land.
    write_reg(REG_POINT_COUNT, 7'd0);
    queue_random(30);
    wait_idle();

    // Random settings.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_POINT_COUNT, 7'($urandom_range(2, 66)));
      write_reg(REG_CLOSED, 7'($urandom_range(0, 1)));
      queue_random(45);
      wait_idle();
    end

    repeat (30) @(posedge clk);
    $display("Run covered %0d table writes and %0d queries (%0d rejected by range).",
             n_writes, n_queries, n_range);
    $display("Config settings spanned zero, one, partial, full and oversized counts.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
